// ----- rtl/bdoc_pkg.sv -----
// shared types, constants and helpers for the binary derivative ones counter
`default_nettype none

package bdoc_pkg;

    localparam int MAX_LEVELS_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int RESULT_CAP      = 32;
    localparam int BYTE_BITS       = 8;
    localparam int OUT_W           = 32;
    localparam int LEVEL_W         = 5;
    localparam int NUM_LEVELS_W    = 6;
    localparam int POP_W           = 4;

    localparam logic [NUM_LEVELS_W-1:0] NUM_LEVELS_RESET = 6'd8;

    // bits handed from one level to the next, index 0 is the oldest bit
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [BYTE_BITS-1:0] mask;
        logic [BYTE_BITS-1:0] bits;
    } link_t;

    // report of one level when the final byte passes it
    typedef struct packed {
        logic               emit;
        logic               hold;
        logic               last_level;
        logic [LEVEL_W-1:0] level;
        logic [OUT_W-1:0]   ones_count;
        logic [OUT_W-1:0]   bit_count;
    } result_t;

    function automatic logic [POP_W-1:0] popcount8(input logic [BYTE_BITS-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < BYTE_BITS; i++)
        begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bdoc_cell.sv -----
// one derivative level: ones counter, last-bit state and xor of adjacent bits
`default_nettype none

module bdoc_cell #(
    parameter int LEVEL       = 0,
    parameter int COUNT_WIDTH = bdoc_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     adv,
    input  wire  [bdoc_pkg::NUM_LEVELS_W-1:0]       levels,
    input  wire  bdoc_pkg::link_t                   link_in,
    input  wire  [COUNT_WIDTH-1:0]                  bits_in,
    output bdoc_pkg::link_t                         link_out,
    output logic [COUNT_WIDTH-1:0]                  bits_out,
    output bdoc_pkg::result_t                       res
);

    localparam int BB = bdoc_pkg::BYTE_BITS;
    localparam int OW = bdoc_pkg::OUT_W;
    localparam int LW = bdoc_pkg::NUM_LEVELS_W + 1;

    bdoc_pkg::link_t        stage_reg;
    logic [COUNT_WIDTH-1:0] bits_reg;
    logic                   prev_bit_reg, prev_bit_next;
    logic                   prev_valid_reg, prev_valid_next;
    logic [COUNT_WIDTH-1:0] ones_reg, ones_next;

    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] ones_new;
    logic [BB-1:0]          dbits;
    logic [BB-1:0]          dmask;
    logic [OW-1:0]          ones_out;
    logic [OW-1:0]          bitcnt_out;
    logic                   at_final;

    always_comb
    begin
        sum = {1'b0, ones_reg} +
              (COUNT_WIDTH+1)'(bdoc_pkg::popcount8(stage_reg.bits & stage_reg.mask));
        ones_new = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

        // bit before position 0 of this byte is the stored bit of the level
        dbits[0] = stage_reg.bits[0] ^ prev_bit_reg;
        dmask[0] = stage_reg.mask[0] & prev_valid_reg;
        for (int i = 1; i < BB; i++)
        begin
            dbits[i] = stage_reg.bits[i] ^
                       (stage_reg.mask[i-1] ? stage_reg.bits[i-1] : prev_bit_reg);
            dmask[i] = stage_reg.mask[i] & (stage_reg.mask[i-1] | prev_valid_reg);
        end

        // valid bits always end at the newest position
        prev_bit_next   = stage_reg.mask[BB-1] ? stage_reg.bits[BB-1] : prev_bit_reg;
        prev_valid_next = prev_valid_reg | stage_reg.mask[BB-1];
        ones_next       = ones_new;
    end

    generate
        if (COUNT_WIDTH > OW) begin : g_clamp
            assign ones_out   = (|ones_new[COUNT_WIDTH-1:OW]) ? '1 : ones_new[OW-1:0];
            assign bitcnt_out = (|bits_reg[COUNT_WIDTH-1:OW]) ? '1 : bits_reg[OW-1:0];
        end else begin : g_ext
            assign ones_out   = OW'(ones_new);
            assign bitcnt_out = OW'(bits_reg);
        end
    endgenerate

    assign at_final = stage_reg.valid & stage_reg.last;

    always_comb
    begin
        link_out.valid = stage_reg.valid;
        link_out.last  = stage_reg.last;
        link_out.mask  = dmask;
        link_out.bits  = dbits;
        bits_out       = (bits_reg == '0) ? '0 : bits_reg - COUNT_WIDTH'(1);

        res.emit       = at_final & (LW'(LEVEL) < {1'b0, levels});
        res.hold       = at_final & (LW'(LEVEL + 1) < {1'b0, levels});
        res.last_level = (LW'(LEVEL + 1) == {1'b0, levels});
        res.level      = bdoc_pkg::LEVEL_W'(LEVEL);
        res.ones_count = ones_out;
        res.bit_count  = bitcnt_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg       <= '0;
            prev_bit_reg    <= 1'b0;
            prev_valid_reg  <= 1'b0;
            ones_reg        <= '0;
        end
        else if (adv)
        begin
            stage_reg <= link_in;
            if (stage_reg.valid)
            begin
                if (stage_reg.last)
                begin
                    prev_bit_reg   <= 1'b0;
                    prev_valid_reg <= 1'b0;
                    ones_reg       <= '0;
                end
                else
                begin
                    prev_bit_reg   <= prev_bit_next;
                    prev_valid_reg <= prev_valid_next;
                    ones_reg       <= ones_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bits_reg <= bits_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/binary_derivative_ones_counter.sv -----
// top level: byte intake, row of derivative level cells and result register
//
// Input stream: s_tdata carries one byte per transfer, bits taken msb first;
// s_tlast marks the final byte of a stream. One byte is taken per cycle while
// s_tready is high. Level p of the derivative lives in cell p of a row of
// MAX_LEVELS cells; a byte moves one cell per cycle while the row advances,
// each cell counting its ones and passing the xor of adjacent bits on to the
// next level. When the final byte reaches cell p, cell p reports level p, so
// the num_levels results of a stream come out one after another, level 0
// first, m_tlast set on the highest level. After a final byte the input takes
// no transfer while the report drains down the row, until the final byte
// reaches the cell of the highest level. Stream length does not matter
// otherwise: every cell clears itself as the final byte passes it, and a new
// stream may follow right behind.
// cfg_wen/cfg_wdata write num_levels (1..32, 0 counts as 1); write it only
// while the block is idle. Reset clears the ones and stream bit counts and sets num_levels to 8.
// When m_tready is low, the row halts only while a level has a result due and
// the result register is full; bytes that report nothing keep moving.
`default_nettype none

module binary_derivative_ones_counter #(
    parameter int MAX_LEVELS  = bdoc_pkg::MAX_LEVELS_DEF,
    parameter int COUNT_WIDTH = bdoc_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_wen,
    input  wire  [bdoc_pkg::NUM_LEVELS_W-1:0]     cfg_wdata,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [7:0]                            s_tdata,   // [7:0] data_byte
    input  wire                                   s_tlast,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [63:0]                           m_tdata,   // [31:0] ones_count, [63:32] bit_count
    output logic [bdoc_pkg::LEVEL_W-1:0]          m_tuser,   // [4:0] level
    output logic                                  m_tlast
);

    localparam int NW = bdoc_pkg::NUM_LEVELS_W;
    localparam int BB = bdoc_pkg::BYTE_BITS;
    localparam int CAP_INT = (MAX_LEVELS < bdoc_pkg::RESULT_CAP) ?
                             MAX_LEVELS : bdoc_pkg::RESULT_CAP;
    localparam logic [NW-1:0] LEVELS_CAP = NW'(CAP_INT);

    logic [NW-1:0]          num_levels_reg;
    logic [NW-1:0]          levels;
    logic [COUNT_WIDTH-1:0] sb_reg, sb_next;
    logic [COUNT_WIDTH:0]   sb_sum;
    logic [COUNT_WIDTH-1:0] sb_total;

    bdoc_pkg::link_t        links [MAX_LEVELS+1];
    logic [COUNT_WIDTH-1:0] bchain [MAX_LEVELS+1];
    bdoc_pkg::result_t      res [MAX_LEVELS];
    logic [MAX_LEVELS-1:0]  emit_vec;
    logic [MAX_LEVELS-1:0]  hold_vec;
    bdoc_pkg::result_t      pick;

    logic                   emit_any;
    logic                   adv;
    logic                   in_xfer;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [63:0]            m_tdata_reg;
    logic [bdoc_pkg::LEVEL_W-1:0] m_tuser_reg;
    logic                   m_tlast_reg;

    always_comb
    begin
        if (num_levels_reg == '0)
            levels = NW'(1);
        else if (num_levels_reg > LEVELS_CAP)
            levels = LEVELS_CAP;
        else
            levels = num_levels_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_levels_reg <= bdoc_pkg::NUM_LEVELS_RESET;
        else if (cfg_wen)
            num_levels_reg <= cfg_wdata;
    end

    // running bit count of the stream, handed down the row with the final byte
    assign sb_sum   = {1'b0, sb_reg} + (COUNT_WIDTH+1)'(BB);
    assign sb_total = sb_sum[COUNT_WIDTH] ? '1 : sb_sum[COUNT_WIDTH-1:0];

    always_comb
    begin
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            emit_vec[i] = res[i].emit;
            hold_vec[i] = res[i].hold;
        end
    end

    assign emit_any = |emit_vec;
    assign adv      = !(emit_any & m_tvalid_reg & !m_tready);
    assign s_tready = adv & !(|hold_vec);
    assign in_xfer  = s_tvalid & s_tready;

    always_comb
    begin
        sb_next = sb_reg;
        if (in_xfer)
            sb_next = s_tlast ? '0 : sb_total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sb_reg <= '0;
        else
            sb_reg <= sb_next;
    end

    always_comb
    begin
        links[0].valid = in_xfer;
        links[0].last  = s_tlast;
        links[0].mask  = '1;
        for (int i = 0; i < BB; i++)
        begin
            links[0].bits[i] = s_tdata[BB-1-i];
        end
        bchain[0] = sb_total;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_LEVELS; g++) begin : g_cell
            bdoc_cell #(
                .LEVEL       (g),
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .levels   (levels),
                .link_in  (links[g]),
                .bits_in  (bchain[g]),
                .link_out (links[g+1]),
                .bits_out (bchain[g+1]),
                .res      (res[g])
            );
        end
    endgenerate

    // at most one cell reports in a cycle
    always_comb
    begin
        pick = '0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if (res[i].emit)
                pick = pick | res[i];
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (adv && emit_any)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit_any)
        begin
            m_tdata_reg <= {pick.bit_count, pick.ones_count};
            m_tuser_reg <= pick.level;
            m_tlast_reg <= pick.last_level;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_one_reporter: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(emit_vec))
        else $error("more than one level reports in a cycle");

    a_level0_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && s_tlast |=> emit_vec[0])
        else $error("level 0 does not report after a final byte");

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && s_tlast |=> sb_reg == '0)
        else $error("stream bit count not cleared after a final byte");

    a_report_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        adv && emit_any |=> m_tvalid)
        else $error("reported level not presented on the output");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (|hold_vec) |-> !s_tready)
        else $error("input taken while a report still drains");
`endif

endmodule

`default_nettype wire
